// ===== rtl/sha512_message_hasher_top_macros.svh =====
// Assertion macros for the SHA-512 message hasher top level.
// Included by sha512_message_hasher_top; depends on nothing else.
`ifndef SHA512_MESSAGE_HASHER_TOP_MACROS_SVH
`define SHA512_MESSAGE_HASHER_TOP_MACROS_SVH

// Assert that an antecedent implies a consequent on the next clock edge.
`define SHA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

// Assert that a condition holds at every clock edge out of reset.
`define SHA_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error(msg);

`endif

// ===== rtl/sha512_pkg.sv =====
// Shared types, constants and functions for the SHA-512 message hasher.
// No dependencies; used by every module of the block by scoped names.
package sha512_pkg;

	localparam int unsigned QueueDepth = 4;
	localparam int unsigned QueueAw    = 2;

	typedef logic [63:0] word_t;

	// One item as it crosses from the front end to the core.
	typedef struct packed {
		logic [63:0] data;
		logic [3:0]  count;
		logic        first;
		logic        last;
	} item_t;

	localparam logic [63:0] InitHash [8] = '{
		64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b,
		64'ha54ff53a5f1d36f1, 64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
		64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
	};

	localparam logic [63:0] RoundK [80] = '{
		64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
		64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
		64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
		64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
		64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
		64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
		64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
		64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
		64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
		64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
		64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
		64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
		64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
		64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
		64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
		64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
		64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
		64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
		64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
		64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
	};

	function automatic logic [63:0] ror64(input logic [63:0] x, input int unsigned n);
		ror64 = (x >> n) | (x << (64 - n));
	endfunction

endpackage

// ===== rtl/sha512_front.sv =====
// Front end: accepts input transactions, clamps the byte count, queues items.
// Depends on sha512_pkg.
module sha512_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [63:0]         in_data,
	input  logic [3:0]          in_count,
	input  logic                in_first,
	input  logic                in_last,
	output logic                q_valid,
	input  logic                q_ready,
	output sha512_pkg::item_t   q_item
);

	sha512_pkg::item_t mem_q [sha512_pkg::QueueDepth];
	logic [sha512_pkg::QueueAw-1:0] wr_q, rd_q;
	logic [sha512_pkg::QueueAw:0]   cnt_q;
	sha512_pkg::item_t in_item;
	logic push, pop;

	always_comb begin
		in_item.data  = in_data;
		in_item.count = (in_count > 4'd8) ? 4'd8 : in_count;
		in_item.first = in_first;
		in_item.last  = in_last;
	end

	assign in_ready = (cnt_q != (sha512_pkg::QueueAw+1)'(sha512_pkg::QueueDepth));
	assign q_valid  = (cnt_q != '0);
	assign q_item   = mem_q[rd_q];
	assign push     = in_valid && in_ready;
	assign pop      = q_valid && q_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			cnt_q <= cnt_q + (sha512_pkg::QueueAw+1)'(push) - (sha512_pkg::QueueAw+1)'(pop);
		end
	end

endmodule

// ===== rtl/sha512_round.sv =====
// One SHA-512 round per cycle with a 16-word rolling message schedule.
// Depends on sha512_pkg.
module sha512_round (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] blk_word [16],
	input  logic [63:0] h_in [8],
	output logic        done,
	output logic [63:0] h_out [8]
);

	logic [63:0] w_q [16];
	logic [63:0] v_q [8];
	logic [63:0] hs_q [8];
	logic [6:0]  t_q;
	logic        busy_q, done_q;
	logic [63:0] x1, x14, s0, s1, wn, wt, t1, t2, s_e, s_a, ch, maj;

	always_comb begin
		x1  = w_q[1];
		x14 = w_q[14];
		s0  = sha512_pkg::ror64(x1, 1) ^ sha512_pkg::ror64(x1, 8) ^ (x1 >> 7);
		s1  = sha512_pkg::ror64(x14, 19) ^ sha512_pkg::ror64(x14, 61) ^ (x14 >> 6);
		wn  = w_q[0] + s0 + w_q[9] + s1;
		wt  = (t_q < 7'd16) ? w_q[0] : wn;
		s_e = sha512_pkg::ror64(v_q[4], 14) ^ sha512_pkg::ror64(v_q[4], 18)
			^ sha512_pkg::ror64(v_q[4], 41);
		s_a = sha512_pkg::ror64(v_q[0], 28) ^ sha512_pkg::ror64(v_q[0], 34)
			^ sha512_pkg::ror64(v_q[0], 39);
		ch  = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
		maj = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
		t1  = v_q[7] + s_e + ch + sha512_pkg::RoundK[t_q] + wt;
		t2  = s_a + maj;
		for (int i = 0; i < 8; i++) begin
			h_out[i] = hs_q[i] + v_q[i];
		end
	end

	assign done = done_q;

	always_ff @(posedge clk) begin
		if (start) begin
			w_q  <= blk_word;
			v_q  <= h_in;
			hs_q <= h_in;
		end else if (busy_q) begin
			// Rotate the schedule window; slot 15 takes W[t], and slot 0 holds W[t] only in rounds 0-15.
			for (int i = 0; i < 15; i++) begin
				w_q[i] <= w_q[i+1];
			end
			w_q[15] <= wt;
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end
	end

	// In rounds 16+, slot 0 must be replaced by the expanded word before use.
	// The rotation above writes wt into slot 15, which is W[t] -> correct
	// for the next expansion since it indexes t-16 relative.

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			t_q    <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				t_q    <= '0;
			end else if (busy_q) begin
				if (t_q == 7'd79) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
					t_q    <= '0;
				end else begin
					t_q <= t_q + 7'd1;
				end
			end
		end
	end

endmodule

// ===== rtl/sha512_core.sv =====
// Back end: absorbs queued items into the block, runs compressions, pads the
// final copy and streams out the digest. Depends on sha512_pkg, sha512_round.
module sha512_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_valid,
	output logic                q_ready,
	input  sha512_pkg::item_t   q_item,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [63:0]         out_word,
	output logic [2:0]          out_index,
	output logic                out_last
);

	localparam logic [3:0] StIdle   = 4'd0;
	localparam logic [3:0] StByte   = 4'd1;
	localparam logic [3:0] StRun    = 4'd2;
	localparam logic [3:0] StWait   = 4'd3;
	localparam logic [3:0] StPadCp  = 4'd4;
	localparam logic [3:0] StPadRun = 4'd5;
	localparam logic [3:0] StPadWt  = 4'd6;
	localparam logic [3:0] StEmit   = 4'd7;

	logic [3:0]  st_q;
	logic [63:0] hash_q [8];
	logic [63:0] fin_q [8];
	logic [63:0] blk_q [16];   // block buffer, byte 0 in bits 63:56 of word 0
	logic [6:0]  fill_q;
	logic [63:0] bytes_q;
	logic [63:0] data_q;
	logic [3:0]  left_q;
	logic        last_q;
	logic        pad2_q;   // second padded block pending
	logic [2:0]  idx_q;
	logic        ov_q;
	logic [63:0] pad_w [16];
	logic [63:0] h_sel [8];
	logic        r_start, r_done;
	logic [63:0] r_h [8];
	logic [6:0]  fill_nx;

	// Padded block image: buffer bytes below fill, 0x80 at fill, zeros after;
	// a second block is zeros. Length fills the last 16 bytes of the length block.
	always_comb begin
		for (int i = 0; i < 16; i++) begin
			for (int b = 0; b < 8; b++) begin
				logic [6:0] p;
				p = 7'(i*8 + b);
				if (pad2_q) begin
					pad_w[i][63-8*b -: 8] = 8'h00;
				end else if (p < fill_q) begin
					pad_w[i][63-8*b -: 8] = blk_q[i][63-8*b -: 8];
				end else if (p == fill_q) begin
					pad_w[i][63-8*b -: 8] = 8'h80;
				end else begin
					pad_w[i][63-8*b -: 8] = 8'h00;
				end
			end
		end
		if (pad2_q || (fill_q < 7'd112)) begin
			pad_w[14] = {61'd0, bytes_q[63:61]};
			pad_w[15] = {bytes_q[60:0], 3'b000};
		end
	end

	assign r_start = (st_q == StRun) || (st_q == StPadRun);
	assign fill_nx = fill_q + 7'd1;

	always_comb begin
		for (int i = 0; i < 8; i++) begin
			h_sel[i] = (st_q == StPadRun) ? fin_q[i] : hash_q[i];
		end
	end

	logic [63:0] r_blk [16];
	always_comb begin
		for (int i = 0; i < 16; i++) begin
			r_blk[i] = (st_q == StPadRun) ? pad_w[i] : blk_q[i];
		end
	end

	sha512_round u_round (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (r_start),
		.blk_word (r_blk),
		.h_in     (h_sel),
		.done     (r_done),
		.h_out    (r_h)
	);

	assign q_ready   = (st_q == StIdle);
	assign out_valid = (st_q == StEmit);
	assign out_word  = fin_q[idx_q];
	assign out_index = idx_q;
	assign out_last  = (idx_q == 3'd7);

	always_ff @(posedge clk) begin
		if ((st_q == StByte) && (left_q != 4'd0)) begin
			blk_q[fill_q[6:3]][63 - 8*fill_q[2:0] -: 8] <= data_q[63:56];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= StIdle;
			hash_q  <= sha512_pkg::InitHash;
			fin_q   <= '{default: '0};
			fill_q  <= '0;
			bytes_q <= '0;
			data_q  <= '0;
			left_q  <= '0;
			last_q  <= 1'b0;
			pad2_q  <= 1'b0;
			idx_q   <= '0;
			ov_q    <= 1'b0;
		end else begin
			case (st_q)
				StIdle: begin
					if (q_valid) begin
						data_q <= q_item.data;
						left_q <= q_item.count;
						last_q <= q_item.last;
						if (q_item.first) begin
							hash_q  <= sha512_pkg::InitHash;
							fill_q  <= '0;
							bytes_q <= 64'(q_item.count);
						end else begin
							bytes_q <= bytes_q + 64'(q_item.count);
						end
						st_q <= StByte;
					end
				end
				StByte: begin
					// One byte per cycle into the block; compress when it fills, pausing the bytes meanwhile.
					if (left_q != 4'd0) begin
						data_q <= {data_q[55:0], 8'h00};
						left_q <= left_q - 4'd1;
						fill_q <= fill_nx;
						if (fill_nx == 7'd0) begin
							st_q <= StRun;
						end
					end else if (last_q) begin
						st_q <= StPadCp;
					end else begin
						st_q <= StIdle;
					end
				end
				StRun: begin
					st_q <= StWait;
				end
				StWait: begin
					if (r_done) begin
						hash_q <= r_h;
						st_q   <= StByte;
					end
				end
				StPadCp: begin
					fin_q  <= hash_q;
					pad2_q <= 1'b0;
					ov_q   <= (fill_q >= 7'd112);
					st_q   <= StPadRun;
				end
				StPadRun: begin
					st_q <= StPadWt;
				end
				StPadWt: begin
					if (r_done) begin
						fin_q <= r_h;
						if (ov_q) begin
							ov_q   <= 1'b0;
							pad2_q <= 1'b1;
							st_q   <= StPadRun;
						end else begin
							pad2_q <= 1'b0;
							idx_q  <= '0;
							st_q   <= StEmit;
						end
					end
				end
				StEmit: begin
					if (out_ready) begin
						idx_q <= idx_q + 3'd1;
						if (idx_q == 3'd7) begin
							st_q <= StIdle;
						end
					end
				end
				default: begin
					st_q <= StIdle;
				end
			endcase
		end
	end

endmodule

// ===== rtl/sha512_message_hasher_top.sv =====
// SHA-512 message hasher: an input transaction waits in the queue, then passes
// through the byte loop, with a compression for each 128-byte block it fills.
// A last item then adds padding (two blocks when 112 or more bytes are left over)
// before 8 output transactions, one per cycle while m_axis_tready is high.
// The queue takes new transactions while the core works on one item at a time.
// arst_n clears control state and seeds the IV.
`include "sha512_message_hasher_top_macros.svh"
module sha512_message_hasher_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [71:0] s_axis_tdata,  // data_word[63:0], valid_bytes[67:64], zero[71:68]
	input  logic        s_axis_tuser,  // first_word
	input  logic        s_axis_tlast,  // last_word
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [63:0] m_axis_tdata,  // digest_word[63:0]
	output logic [2:0]  m_axis_tuser,  // word_index[2:0]
	output logic        m_axis_tlast   // digest_last
);

	logic              q_valid, q_ready;
	sha512_pkg::item_t q_item;

	// Front end: take transactions and queue them.
	sha512_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_data  (s_axis_tdata[63:0]),
		.in_count (s_axis_tdata[67:64]),
		.in_first (s_axis_tuser),
		.in_last  (s_axis_tlast),
		.q_valid  (q_valid),
		.q_ready  (q_ready),
		.q_item   (q_item)
	);

	// Back end: absorb, compress, pad and emit.
	sha512_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_ready   (q_ready),
		.q_item    (q_item),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_word  (m_axis_tdata),
		.out_index (m_axis_tuser),
		.out_last  (m_axis_tlast)
	);

	`SHA_ASSERT_ALWAYS(a_last_idx, clk, arst_n, !m_axis_tvalid || (m_axis_tlast == (m_axis_tuser == 3'd7)), "tlast mismatch")
	`SHA_ASSERT_NEXT(a_idx_step, clk, arst_n, m_axis_tvalid && m_axis_tready && !m_axis_tlast, m_axis_tvalid && (m_axis_tuser == $past(m_axis_tuser) + 3'd1), "digest index skipped")
	`SHA_ASSERT_ALWAYS(a_no_pop_emit, clk, arst_n, !(q_ready && m_axis_tvalid), "queue pop during emit")

endmodule
